>>> rtl/core/scd_pkg.sv
// Shared types, codes and command decode functions of the SPI command deframer.
package scd_pkg;

   localparam int MAX_PAYLOAD = 8;
   localparam int PAYLOAD_AW = $clog2(MAX_PAYLOAD);

   localparam logic ACT_EXCHANGE = 1'b0;
   localparam logic ACT_PUSH     = 1'b1;

   localparam logic [3:0] KIND_NOP        = 4'd0;
   localparam logic [3:0] KIND_RGB_OFF    = 4'd1;
   localparam logic [3:0] KIND_RGB_SET    = 4'd2;
   localparam logic [3:0] KIND_LED        = 4'd3;
   localparam logic [3:0] KIND_BRIGHTNESS = 4'd4;
   localparam logic [3:0] KIND_DISPLAY    = 4'd5;
   localparam logic [3:0] KIND_REFRESH    = 4'd6;
   localparam logic [3:0] KIND_OFF        = 4'd7;
   localparam logic [3:0] KIND_CLEAR      = 4'd8;
   localparam logic [3:0] KIND_IGNORED    = 4'd9;

   localparam logic [7:0] CMD_GROUP_RGB4  = 8'b1100_0000;
   localparam logic [7:0] CMD_GROUP_DISP8 = 8'b1101_0000;
   localparam logic [7:0] CMD_GROUP_MASK  = 8'b1111_0000;
   localparam logic [7:0] CMD_LOW_MASK    = 8'hE0;
   localparam logic [7:0] CMD_NOP         = 8'd0;
   localparam logic [7:0] CMD_RGB_OFF     = 8'd31;
   localparam logic [7:0] CMD_REFRESH     = 8'b1111_0000;
   localparam logic [7:0] CMD_SUB_MASK    = 8'b0001_1000;
   localparam logic [7:0] CMD_SUB_CLEAR   = 8'b0000_1000;
   localparam logic [7:0] CMD_BIT_HIGH    = 8'b0010_0000;

   localparam logic [3:0] LEN_RGB4  = 4'd4;
   localparam logic [3:0] LEN_DISP8 = 4'd8;
   localparam logic [3:0] LEN_LOW   = 4'd5;
   localparam logic [3:0] LEN_NONE  = 4'd0;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
      logic [7:0] report_header;
      logic [7:0] report_data;
   } request_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       msg_valid;
      logic [3:0] msg_kind;
      logic [7:0] command_byte;
      logic [3:0] payload_count;
      logic       payload_valid;
      logic [2:0] payload_index;
      logic [7:0] payload_byte;
      logic       last;
      logic       send_dropped;
   } result_type;

   typedef struct packed {
      logic       exchange;
      logic       push;
      logic [7:0] header;
      logic [7:0] data;
   } queue_ctl_type;

   typedef struct packed {
      logic [7:0] reply;
      logic       dropped;
      logic       drop_now;
      logic       busy;
   } queue_stat_type;

   typedef struct packed {
      logic                  we;
      logic [PAYLOAD_AW-1:0] waddr;
      logic [7:0]            wdata;
      logic                  re;
      logic [PAYLOAD_AW-1:0] raddr;
   } payload_ctl_type;

   function automatic logic [3:0] length_of(input logic [7:0] cmd);
      logic [3:0] len;
      len = LEN_NONE;
      if ((cmd & CMD_GROUP_MASK) == CMD_GROUP_RGB4) begin
         len = LEN_RGB4;
      end else if ((cmd & CMD_GROUP_MASK) == CMD_GROUP_DISP8) begin
         len = LEN_DISP8;
      end else if ((cmd & CMD_LOW_MASK) == CMD_NOP && cmd != CMD_NOP && cmd != CMD_RGB_OFF) begin
         len = LEN_LOW;
      end
      return len;
   endfunction

   function automatic logic [3:0] kind_of(input logic [7:0] cmd);
      logic [3:0] kind;
      case (cmd[7:6])
         2'b00: begin
            if (cmd == CMD_NOP) kind = KIND_NOP;
            else if (cmd == CMD_RGB_OFF) kind = KIND_RGB_OFF;
            else kind = KIND_RGB_SET;
         end
         2'b01: kind = KIND_LED;
         2'b10: kind = KIND_BRIGHTNESS;
         default: begin
            if ((cmd & CMD_BIT_HIGH) == CMD_NOP) kind = KIND_DISPLAY;
            else if (cmd == CMD_REFRESH) kind = KIND_REFRESH;
            else if ((cmd & CMD_SUB_MASK) == CMD_NOP) kind = KIND_OFF;
            else if ((cmd & CMD_SUB_MASK) == CMD_SUB_CLEAR) kind = KIND_CLEAR;
            else kind = KIND_IGNORED;
         end
      endcase
      return kind;
   endfunction

endpackage

>>> rtl/core/scd_payload_store.sv
// Payload byte memory of the message being collected, one write and one read port.
module scd_payload_store (
   input  logic                      clock,
   input  scd_pkg::payload_ctl_type  ctl,
   output logic [7:0]                rdata
);

   logic [7:0] mem [scd_pkg::MAX_PAYLOAD];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rdata_ff <= mem[ctl.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/scd_reply_queue.sv
// Reply byte queue: ring memory, pointers, preloaded reply and drop flag.
module scd_reply_queue #(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  scd_pkg::queue_ctl_type   ctl,
   output scd_pkg::queue_stat_type  stat
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW:0] FIT_LIMIT = (AW + 1)'(DEPTH - 3);

   logic [7:0]    mem [DEPTH];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [7:0]    next_reply_ff, next_reply_in;
   logic          pend_ff, pend_in;
   logic          dropped_ff, dropped_in;
   logic          wr2_ff, wr2_in;
   logic [AW-1:0] wr2_addr_ff, wr2_addr_in;
   logic [7:0]    wr2_data_ff, wr2_data_in;
   logic          we;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;
   logic          re;
   logic          empty;
   logic          fits;
   logic [AW:0]   occ;
   logic [AW-1:0] wr_ptr_p1;
   logic [7:0]    reply_now;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      empty = (rd_ptr_ff == wr_ptr_ff);
      if (wr_ptr_ff >= rd_ptr_ff) begin
         occ = {1'b0, wr_ptr_ff} - {1'b0, rd_ptr_ff};
      end else begin
         occ = {1'b0, wr_ptr_ff} + DEPTH_W - {1'b0, rd_ptr_ff};
      end
      fits = empty || (occ <= FIT_LIMIT);
      wr_ptr_p1 = ptr_next(wr_ptr_ff);
      reply_now = pend_ff ? rdata_ff : next_reply_ff;

      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      next_reply_in = reply_now;
      pend_in = 1'b0;
      dropped_in = dropped_ff;
      wr2_in = 1'b0;
      wr2_addr_in = wr2_addr_ff;
      wr2_data_in = wr2_data_ff;
      we = wr2_ff;
      waddr = wr2_addr_ff;
      wdata = wr2_data_ff;
      re = 1'b0;

      if (ctl.exchange) begin
         if (empty) begin
            next_reply_in = 8'd0;
         end else begin
            re = 1'b1;
            pend_in = 1'b1;
            rd_ptr_in = ptr_next(rd_ptr_ff);
         end
      end else if (ctl.push) begin
         if (!fits) begin
            dropped_in = 1'b1;
         end else if (empty) begin
            next_reply_in = ctl.header;
            rd_ptr_in = ptr_next(rd_ptr_ff);
            we = 1'b1;
            waddr = wr_ptr_p1;
            wdata = ctl.data;
            wr_ptr_in = ptr_next(wr_ptr_p1);
         end else begin
            we = 1'b1;
            waddr = wr_ptr_ff;
            wdata = ctl.header;
            wr2_in = 1'b1;
            wr2_addr_in = wr_ptr_p1;
            wr2_data_in = ctl.data;
            wr_ptr_in = ptr_next(wr_ptr_p1);
         end
      end

      stat.reply = reply_now;
      stat.dropped = dropped_ff;
      stat.drop_now = ctl.push && !fits;
      stat.busy = wr2_ff;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
      wr2_addr_ff <= wr2_addr_in;
      wr2_data_ff <= wr2_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         next_reply_ff <= 8'd0;
         pend_ff <= 1'b0;
         dropped_ff <= 1'b0;
         wr2_ff <= 1'b0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         next_reply_ff <= next_reply_in;
         pend_ff <= pend_in;
         dropped_ff <= dropped_in;
         wr2_ff <= wr2_in;
      end
   end

endmodule

>>> rtl/core/spi_command_deframer.sv
// Top level of the SPI command deframer: input stage, sequencer, deframer and result register.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   action, rx_byte, report_header, report_data
//   rsp      out        rsp_valid/rsp_ready   reply, message, payload byte, last, drop flag
//
// An exchange yields one response, plus one per payload byte when it completes a message
// (up to 8), paced by the payload memory read port, one byte a cycle while rsp is not stalled.
// A queue action stores its pair with one write, two when the pair is stored behind queued
// bytes (single write port), the queue being busy for the second; a dropped pair writes nothing.
// Reset is synchronous; the memories need no clearing pass.
// A stalled rsp holds the sequencer; one request waits in the input stage meanwhile.
module spi_command_deframer #(
   parameter int REPLY_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_report_header,
   input  logic [7:0] req_report_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_reply_byte,
   output logic       rsp_msg_valid,
   output logic [3:0] rsp_msg_kind,
   output logic [7:0] rsp_command_byte,
   output logic [3:0] rsp_payload_count,
   output logic       rsp_payload_valid,
   output logic [2:0] rsp_payload_index,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last,
   output logic       rsp_send_dropped
);

   scd_pkg::request_type     req_ff, req_in;
   logic                     req_full_ff, req_full_in;
   scd_pkg::result_type      rsp_ff, rsp_in;
   logic                     rsp_full_ff, rsp_full_in;
   scd_pkg::state_type       state_ff, state_in;
   logic                     collecting_ff, collecting_in;
   logic [7:0]               held_ff, held_in;
   logic [3:0]               expected_ff, expected_in;
   logic [3:0]               received_ff, received_in;
   logic [7:0]               emit_cmd_ff, emit_cmd_in;
   logic [3:0]               emit_kind_ff, emit_kind_in;
   logic [3:0]               emit_count_ff, emit_count_in;
   logic [2:0]               emit_idx_ff, emit_idx_in;
   scd_pkg::queue_ctl_type   q_ctl;
   scd_pkg::queue_stat_type  q_stat;
   scd_pkg::payload_ctl_type pl_ctl;
   logic [7:0]               pl_rdata;
   logic                     can_go;
   logic                     start;
   logic                     done;
   logic [3:0]               len;
   logic [3:0]               recv_sum;
   logic [7:0]               cmd;
   logic [3:0]               count;
   logic                     emit_end;

   scd_reply_queue #(
      .DEPTH(REPLY_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .ctl(q_ctl),
      .stat(q_stat)
   );

   scd_payload_store u_payload (
      .clock(clock),
      .ctl(pl_ctl),
      .rdata(pl_rdata)
   );

   always_comb begin
      can_go = !rsp_full_ff || rsp_ready;
      start = req_full_ff && (state_ff == scd_pkg::ST_IDLE) && can_go && !q_stat.busy;
      req_ready = !req_full_ff || start;
      emit_end = (({1'b0, emit_idx_ff} + 4'd1) == emit_count_ff);

      req_in = req_ff;
      req_full_in = req_full_ff && !start;
      if (req_valid && req_ready) begin
         req_in.action = req_action;
         req_in.rx_byte = req_rx_byte;
         req_in.report_header = req_report_header;
         req_in.report_data = req_report_data;
         req_full_in = 1'b1;
      end

      rsp_in = rsp_ff;
      rsp_full_in = rsp_full_ff && !rsp_ready;
      state_in = state_ff;
      collecting_in = collecting_ff;
      held_in = held_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      emit_cmd_in = emit_cmd_ff;
      emit_kind_in = emit_kind_ff;
      emit_count_in = emit_count_ff;
      emit_idx_in = emit_idx_ff;
      q_ctl = '0;
      pl_ctl = '0;
      done = 1'b0;
      len = scd_pkg::length_of(req_ff.rx_byte);
      recv_sum = received_ff + 4'd1;
      cmd = held_ff;
      count = expected_ff;

      case (state_ff)
         scd_pkg::ST_IDLE: begin
            if (start) begin
               rsp_full_in = 1'b1;
               rsp_in = '0;
               if (req_ff.action == scd_pkg::ACT_PUSH) begin
                  q_ctl.push = 1'b1;
                  q_ctl.header = req_ff.report_header;
                  q_ctl.data = req_ff.report_data;
                  rsp_in.last = 1'b1;
                  rsp_in.send_dropped = q_stat.dropped || q_stat.drop_now;
               end else begin
                  q_ctl.exchange = 1'b1;
                  if (!collecting_ff) begin
                     held_in = req_ff.rx_byte;
                     expected_in = len;
                     received_in = 4'd0;
                     done = (len == scd_pkg::LEN_NONE);
                     collecting_in = !done;
                     cmd = req_ff.rx_byte;
                     count = len;
                  end else begin
                     pl_ctl.we = 1'b1;
                     pl_ctl.waddr = received_ff[scd_pkg::PAYLOAD_AW-1:0];
                     pl_ctl.wdata = req_ff.rx_byte;
                     received_in = recv_sum;
                     done = (recv_sum >= expected_ff);
                     collecting_in = !done;
                  end
                  // first payload byte is never the one written now
                  pl_ctl.re = 1'b1;
                  pl_ctl.raddr = '0;
                  rsp_in.reply_byte = q_stat.reply;
                  rsp_in.send_dropped = q_stat.dropped;
                  if (done) begin
                     rsp_in.msg_valid = 1'b1;
                     rsp_in.msg_kind = scd_pkg::kind_of(cmd);
                     rsp_in.command_byte = cmd;
                     rsp_in.payload_count = count;
                  end
                  rsp_in.last = !(done && count != 4'd0);
                  if (done && count != 4'd0) begin
                     state_in = scd_pkg::ST_EMIT;
                     emit_cmd_in = cmd;
                     emit_kind_in = scd_pkg::kind_of(cmd);
                     emit_count_in = count;
                     emit_idx_in = 3'd0;
                  end
               end
            end
         end
         scd_pkg::ST_EMIT: begin
            if (can_go) begin
               rsp_full_in = 1'b1;
               rsp_in.reply_byte = 8'd0;
               rsp_in.msg_valid = 1'b1;
               rsp_in.msg_kind = emit_kind_ff;
               rsp_in.command_byte = emit_cmd_ff;
               rsp_in.payload_count = emit_count_ff;
               rsp_in.payload_valid = 1'b1;
               rsp_in.payload_index = emit_idx_ff;
               rsp_in.payload_byte = pl_rdata;
               rsp_in.last = emit_end;
               rsp_in.send_dropped = q_stat.dropped;
               pl_ctl.re = 1'b1;
               pl_ctl.raddr = emit_idx_ff + 3'd1;
               emit_idx_in = emit_idx_ff + 3'd1;
               if (emit_end) begin
                  state_in = scd_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = scd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
         rsp_full_ff <= 1'b0;
         state_ff <= scd_pkg::ST_IDLE;
         collecting_ff <= 1'b0;
         held_ff <= 8'd0;
         expected_ff <= 4'd0;
         received_ff <= 4'd0;
      end else begin
         req_full_ff <= req_full_in;
         rsp_full_ff <= rsp_full_in;
         state_ff <= state_in;
         collecting_ff <= collecting_in;
         held_ff <= held_in;
         expected_ff <= expected_in;
         received_ff <= received_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      emit_cmd_ff <= emit_cmd_in;
      emit_kind_ff <= emit_kind_in;
      emit_count_ff <= emit_count_in;
      emit_idx_ff <= emit_idx_in;
   end

   assign rsp_valid = rsp_full_ff;
   assign rsp_reply_byte = rsp_ff.reply_byte;
   assign rsp_msg_valid = rsp_ff.msg_valid;
   assign rsp_msg_kind = rsp_ff.msg_kind;
   assign rsp_command_byte = rsp_ff.command_byte;
   assign rsp_payload_count = rsp_ff.payload_count;
   assign rsp_payload_valid = rsp_ff.payload_valid;
   assign rsp_payload_index = rsp_ff.payload_index;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_last = rsp_ff.last;
   assign rsp_send_dropped = rsp_ff.send_dropped;

   a_emit_index_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == scd_pkg::ST_EMIT |-> emit_count_ff != 4'd0 &&
      {1'b0, emit_idx_ff} < emit_count_ff)
      else $error("payload index beyond message length");

   a_collect_count: assert property (@(posedge clock) disable iff (reset)
      collecting_ff |-> received_ff < expected_ff)
      else $error("collecting past expected length");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_full_ff && rsp_ff.payload_valid |-> rsp_ff.msg_valid && rsp_ff.reply_byte == 8'd0)
      else $error("payload item without message fields");

   a_emit_close: assert property (@(posedge clock) disable iff (reset)
      state_ff == scd_pkg::ST_EMIT && can_go && emit_end |=>
      rsp_ff.last && state_ff == scd_pkg::ST_IDLE)
      else $error("final payload item not marked last");

   a_queue_interlock: assert property (@(posedge clock) disable iff (reset)
      q_stat.busy |-> !q_ctl.exchange && !q_ctl.push)
      else $error("queue access during second write");

endmodule
